FILE: src/citbc_pkg.sv
// Shared types, codes and helpers for the counter indexed table byte cipher.
package citbc_pkg;

    localparam int TBL_DEPTH = 512;

    localparam logic [7:0] WHITEN = 8'hAB;

    // Configuration register indexes
    localparam logic CFG_P_SEED = 1'b0;
    localparam logic CFG_G_SEED = 1'b1;

    typedef enum logic [1:0] {
        OP_ENCRYPT  = 2'd0,
        OP_DECRYPT  = 2'd1,
        OP_RST_CNT  = 2'd2,
        OP_GENERATE = 2'd3
    } t_op;

    // Operand set for the shared multiply-accumulate unit: y = c +/- a*b (mod 256)
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       sub;
    } t_mac_req;

    function automatic logic [7:0] swap_nibbles(input logic [7:0] x);
        return {x[3:0], x[7:4]};
    endfunction

endpackage

FILE: src/citbc_mac.sv
// Shared 8-bit multiply-accumulate unit with a registered result.
module citbc_mac import citbc_pkg::*; (
    input  logic       i_clk,
    input  t_mac_req   i_req,
    output logic [7:0] o_y
);

    logic [15:0] prod;
    logic [7:0]  n_y;
    logic [7:0]  r_y;

    assign prod = i_req.a * i_req.b;

    always_comb begin
        if (i_req.sub) begin
            n_y = i_req.c - prod[7:0];
        end else begin
            n_y = i_req.c + prod[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_y = r_y;

endmodule

FILE: src/citbc_key_ram.sv
// Key table store: one write port, one registered read port.
module citbc_key_ram import citbc_pkg::*; #(
    parameter int DEPTH = TBL_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/counter_indexed_table_byte_cipher.sv
// Top level: sequencer, counters, configuration and output register of the byte cipher.
//
// Byte cipher with two 256-entry key tables held in one 512 x 8 store. An encrypt or
// decrypt transaction reads its two table entries one after the other through the
// single registered read port of the key store, then the result is folded and placed in
// the output register, where it may wait while the next transaction is accepted. A
// counter reset gives no result. Table generation writes each entry pair while the
// single shared multiply-accumulate unit evaluates both recurrences in turn; it gives no
// result and leaves the counters alone. Until the first generation the table XORs are
// bypassed, so the store needs no clearing after reset. Seeds are written through the
// configuration port by the user only while the block is idle; the block itself does
// not enforce it. Seeds take effect at the next generation.
module counter_indexed_table_byte_cipher import citbc_pkg::*; #(
    parameter int TABLE_DEPTH = TBL_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_in,
    input  logic        i_last_in,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_out,
    output logic        o_last_out,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int HALF = TABLE_DEPTH / 2;
    localparam int IW   = $clog2(HALF);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_GEN0 = 10'b00_0000_0010,
        S_GEN1 = 10'b00_0000_0100,
        S_GEN2 = 10'b00_0000_1000,
        S_GEN3 = 10'b00_0001_0000,
        S_GEN4 = 10'b00_0010_0000,
        S_RD0  = 10'b00_0100_0000,
        S_RD1  = 10'b00_1000_0000,
        S_RD2  = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    t_state        r_state, n_state;
    logic          r_table_ready, n_table_ready;
    logic [15:0]   r_enc_cnt, n_enc_cnt;
    logic [15:0]   r_dec_cnt, n_dec_cnt;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_p_seed, r_g_seed;

    logic [7:0]    r_x, n_x;
    logic [15:0]   r_cnt, n_cnt;
    logic          r_is_enc, n_is_enc;
    logic          r_last, n_last;
    logic [7:0]    r_p0, n_p0;
    logic [7:0]    r_g0, n_g0;
    logic [7:0]    r_data_out, n_data_out;
    logic          r_last_out, n_last_out;

    logic          in_acc;
    logic          cfg_acc;
    t_op           op;

    t_mac_req      mac_req;
    logic [7:0]    mac_y;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    key_mask;
    logic [7:0]    mixed;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign op          = t_op'(i_operation);

    // Before the first generation the table entries are undefined and stay masked out
    assign key_mask = r_table_ready ? ram_rdata : 8'h00;
    assign mixed    = r_x ^ key_mask;

    citbc_mac u_mac (
        .i_clk (i_clk),
        .i_req (mac_req),
        .o_y   (mac_y)
    );

    citbc_key_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_table_ready = r_table_ready;
        n_enc_cnt     = r_enc_cnt;
        n_dec_cnt     = r_dec_cnt;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_x           = r_x;
        n_cnt         = r_cnt;
        n_is_enc      = r_is_enc;
        n_last        = r_last;
        n_p0          = r_p0;
        n_g0          = r_g0;
        n_data_out    = r_data_out;
        n_last_out    = r_last_out;

        mac_req       = '0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(r_idx);
        ram_wdata     = r_p0;
        ram_raddr     = AW'(HALF) + AW'(r_cnt[15:8]);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last = i_last_in;
                    unique case (op)
                        OP_ENCRYPT: begin
                            n_x       = i_data_in;
                            n_cnt     = r_enc_cnt;
                            n_is_enc  = 1'b1;
                            n_enc_cnt = r_enc_cnt + 16'd1;
                            n_state   = S_RD0;
                        end
                        OP_DECRYPT: begin
                            n_x       = swap_nibbles(i_data_in ^ WHITEN);
                            n_cnt     = r_dec_cnt;
                            n_is_enc  = 1'b0;
                            n_dec_cnt = r_dec_cnt + 16'd1;
                            n_state   = S_RD0;
                        end
                        OP_RST_CNT: begin
                            n_enc_cnt = '0;
                            n_dec_cnt = '0;
                        end
                        OP_GENERATE: begin
                            n_p0    = r_p_seed[7:0];
                            n_g0    = r_g_seed[7:0];
                            n_idx   = '0;
                            n_state = S_GEN0;
                        end
                        default: ;
                    endcase
                end
            end
            // first table entry, then t = p1 + p0*p2
            S_GEN0: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_idx);
                ram_wdata = r_p0;
                mac_req   = '{a: r_p0, b: r_p_seed[23:16], c: r_p_seed[15:8], sub: 1'b0};
                n_state   = S_GEN1;
            end
            // second table entry, then p0' = t*p0 + p3
            S_GEN1: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(HALF) + AW'(r_idx);
                ram_wdata = r_g0;
                mac_req   = '{a: mac_y, b: r_p0, c: r_p_seed[31:24], sub: 1'b0};
                n_state   = S_GEN2;
            end
            // t = g1 - g0*g2
            S_GEN2: begin
                n_p0    = mac_y;
                mac_req = '{a: r_g0, b: r_g_seed[23:16], c: r_g_seed[15:8], sub: 1'b1};
                n_state = S_GEN3;
            end
            // g0' = t*g0 + g3
            S_GEN3: begin
                mac_req = '{a: mac_y, b: r_g0, c: r_g_seed[31:24], sub: 1'b0};
                n_state = S_GEN4;
            end
            S_GEN4: begin
                n_g0  = mac_y;
                n_idx = r_idx + IW'(1);
                if (r_idx == IW'(HALF - 1)) begin
                    n_table_ready = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_GEN0;
                end
            end
            S_RD0: begin
                ram_raddr = AW'(r_cnt[7:0]);
                n_state   = S_RD1;
            end
            // low-byte entry arrives; high-byte entry requested
            S_RD1: begin
                n_x     = mixed;
                n_state = S_RD2;
            end
            S_RD2: begin
                n_x     = r_is_enc ? (swap_nibbles(mixed) ^ WHITEN) : mixed;
                n_state = S_OUT;
            end
            // wait for the output register to be free
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_data_out  = r_x;
                    n_last_out  = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_table_ready <= 1'b0;
            r_enc_cnt     <= '0;
            r_dec_cnt     <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_table_ready <= n_table_ready;
            r_enc_cnt     <= n_enc_cnt;
            r_dec_cnt     <= n_dec_cnt;
            r_idx         <= n_idx;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_seed <= '0;
            r_g_seed <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_P_SEED: r_p_seed <= i_cfg_data;
                CFG_G_SEED: r_g_seed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_cnt      <= n_cnt;
        r_is_enc   <= n_is_enc;
        r_last     <= n_last;
        r_p0       <= n_p0;
        r_g0       <= n_g0;
        r_data_out <= n_data_out;
        r_last_out <= n_last_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_last_out  = r_last_out;

    a_ram_write_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_GEN0 || r_state == S_GEN1))
        else $error("key store written outside table generation");

    a_enc_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && op == OP_ENCRYPT) |=> (r_enc_cnt == 16'($past(r_enc_cnt) + 16'd1)))
        else $error("encrypt counter did not advance");

    a_gen_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN4 && r_idx == IW'(HALF - 1)) |=> (r_table_ready && o_in_ready))
        else $error("generation end did not mark tables ready");

    a_idx_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_GEN4 && !in_acc) |=> $stable(r_idx))
        else $error("table index moved outside generation");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the counter indexed table byte cipher.
`timescale 1ns / 1ps

module tb;
    import citbc_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RST_CYCLES    = 9;
    localparam int SETTLE_CYCLES = 1400;      // covers a full table generation pass
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SWEEP_ITEMS   = 64;
    localparam int PRINT_CAP     = 32;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_res;

    typedef struct packed {
        bit         is_cfg;
        t_op        op;
        logic [7:0] data;
        logic       last;
        bit         typed;
        logic [7:0] want;
        logic [31:0] p_val;
        logic [31:0] g_val;
    } t_dir_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = OP_ENCRYPT;
    logic [7:0]  i_data_in   = 8'h00;
    logic        i_last_in   = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_data_out;
    logic        o_last_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_P_SEED;
    logic [31:0] i_cfg_data  = 32'h0;

    counter_indexed_table_byte_cipher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_data_in   (i_data_in),
        .i_last_in   (i_last_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_out  (o_data_out),
        .o_last_out  (o_last_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // cipher state as the predictor sees it
    logic [7:0]  key_p [256];
    logic [7:0]  key_g [256];
    bit          keys_loaded = 1'b0;
    logic [15:0] enc_cnt     = 16'd0;
    logic [15:0] dec_cnt     = 16'd0;
    logic [31:0] seed_p      = 32'h0;
    logic [31:0] seed_g      = 32'h0;

    t_byte_res   pending_bytes [$];
    t_byte_res   rx_want;
    t_dir_row    dir_tbl [$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int cycle_cnt    = 0;
    int mismatch_cnt = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int gens_sent    = 0;
    int resets_sent  = 0;

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (mismatch_cnt < PRINT_CAP)
            $display("mismatch at result %0d: %s got %02h want %02h",
                     results_seen, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic predict_byte(input t_op op, input logic [7:0] din, input logic lst,
                                output bit has_res, output t_byte_res res);
        logic [7:0] x;
        logic [7:0] p0, p1, p2, p3, g0, g1, g2, g3, tp, tg;
        int         i;
        has_res = 1'b0;
        x       = din;
        case (op)
            OP_ENCRYPT: begin
                if (keys_loaded)
                    x = x ^ key_p[enc_cnt[7:0]] ^ key_g[enc_cnt[15:8]];
                x       = {x[3:0], x[7:4]} ^ WHITEN;
                enc_cnt = enc_cnt + 16'd1;
                has_res = 1'b1;
            end
            OP_DECRYPT: begin
                x = x ^ WHITEN;
                x = {x[3:0], x[7:4]};
                if (keys_loaded)
                    x = x ^ key_p[dec_cnt[7:0]] ^ key_g[dec_cnt[15:8]];
                dec_cnt = dec_cnt + 16'd1;
                has_res = 1'b1;
            end
            OP_RST_CNT: begin
                enc_cnt = 16'd0;
                dec_cnt = 16'd0;
            end
            default: begin
                {p3, p2, p1, p0} = seed_p;
                {g3, g2, g1, g0} = seed_g;
                for (i = 0; i < 256; i++) begin
                    key_p[i] = p0;
                    key_g[i] = g0;
                    // both recurrences wrap at 8 bits
                    tp = p1 + p0 * p2;
                    p0 = tp * p0 + p3;
                    tg = g1 - g0 * g2;
                    g0 = tg * g0 + g3;
                end
                keys_loaded = 1'b1;
            end
        endcase
        res.data = x;
        res.last = lst;
    endtask

    task automatic send_item(input t_op op, input logic [7:0] din, input logic lst,
                             input bit typed, input logic [7:0] want);
        bit        has_res;
        t_byte_res res;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_in   <= din;
        i_last_in   <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        predict_byte(op, din, lst, has_res, res);
        if (has_res) begin
            if (typed)
                res.data = want;
            pending_bytes.push_back(res);
        end
        items_sent++;
        if (op == OP_GENERATE)
            gens_sent++;
        if (op == OP_RST_CNT)
            resets_sent++;
    endtask

    task automatic wait_drained();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    // a generate gives no result, so let any pass in flight finish as well
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_seeds(input logic [31:0] p_val, input logic [31:0] g_val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_P_SEED;
        i_cfg_data  <= p_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_p = p_val;
        i_cfg_index <= CFG_G_SEED;
        i_cfg_data  <= g_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_g = g_val;
        i_cfg_valid <= 1'b0;
    endtask

    // mostly buffers of one direction closed by last, with some stray bytes,
    // counter resets and regenerations mixed in
    task automatic run_random(input int n_items);
        int  sent;
        int  len;
        int  r;
        int  j;
        t_op op;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 3) begin
                send_item(OP_GENERATE, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
                sent++;
            end else if (r < 7) begin
                send_item(OP_RST_CNT, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
                sent++;
            end else if (r < 15) begin
                op = ($urandom_range(1) != 0) ? OP_DECRYPT : OP_ENCRYPT;
                send_item(op, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
                sent++;
            end else begin
                len = $urandom_range(24, 1);
                op  = ($urandom_range(1) != 0) ? OP_DECRYPT : OP_ENCRYPT;
                for (j = 0; j < len; j++)
                    send_item(op, 8'($urandom), (j == len - 1), 1'b0, 8'h00);
                sent += len;
            end
        end
    endtask

    function automatic t_dir_row item_row(input t_op op, input logic [7:0] d, input logic l,
                                          input bit typed, input logic [7:0] want);
        t_dir_row r;
        r       = '0;
        r.op    = op;
        r.data  = d;
        r.last  = l;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [31:0] p_val, input logic [31:0] g_val);
        t_dir_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.p_val  = p_val;
        r.g_val  = g_val;
        return r;
    endfunction

    // result checking and receiver back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bytes.size() == 0) begin
                flag_mismatch("result with nothing expected, data_out", o_data_out, 8'h00);
            end else begin
                rx_want = pending_bytes.pop_front();
                if (o_data_out !== rx_want.data)
                    flag_mismatch("data_out", o_data_out, rx_want.data);
                if (o_last_out !== rx_want.last)
                    flag_mismatch("last_out", {7'd0, o_last_out}, {7'd0, rx_want.last});
            end
            results_seen++;
        end
        if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     pending_bytes.size());
            $display("[counter_indexed_table_byte_cipher] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        // before any generation: table XORs bypassed, so results follow from the byte alone
        dir_tbl.push_back(item_row(OP_ENCRYPT,  8'h00, 1'b0, 1'b1, 8'hAB));
        dir_tbl.push_back(item_row(OP_ENCRYPT,  8'hFF, 1'b1, 1'b1, 8'h54));
        dir_tbl.push_back(item_row(OP_DECRYPT,  8'hAB, 1'b0, 1'b1, 8'h00));
        dir_tbl.push_back(item_row(OP_DECRYPT,  8'h54, 1'b1, 1'b1, 8'hFF));
        dir_tbl.push_back(item_row(OP_RST_CNT,  8'h00, 1'b0, 1'b0, 8'h00));
        // zero seeds give all-zero tables
        dir_tbl.push_back(item_row(OP_GENERATE, 8'h00, 1'b0, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_ENCRYPT,  8'h00, 1'b0, 1'b1, 8'hAB));
        dir_tbl.push_back(item_row(OP_DECRYPT,  8'hFF, 1'b1, 1'b1, 8'h45));
        dir_tbl.push_back(cfg_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir_tbl.push_back(item_row(OP_GENERATE, 8'hFF, 1'b1, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_ENCRYPT,  8'h5A, 1'b0, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_DECRYPT,  8'h5A, 1'b1, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_ENCRYPT,  8'hFF, 1'b1, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_DECRYPT,  8'h00, 1'b0, 1'b0, 8'h00));
        // new seeds, old tables stay in use until the next generate
        dir_tbl.push_back(cfg_row(32'h9E37_79B9, 32'h7F4A_7C15));
        dir_tbl.push_back(item_row(OP_ENCRYPT,  8'hA5, 1'b0, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_DECRYPT,  8'hC3, 1'b1, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_GENERATE, 8'h00, 1'b0, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_ENCRYPT,  8'h3C, 1'b0, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_RST_CNT,  8'hFF, 1'b1, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_ENCRYPT,  8'h00, 1'b1, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_DECRYPT,  8'hFF, 1'b0, 1'b0, 8'h00));
        // regenerating must leave the counters where they are
        dir_tbl.push_back(item_row(OP_GENERATE, 8'hFF, 1'b1, 1'b0, 8'h00));
        dir_tbl.push_back(item_row(OP_ENCRYPT,  8'h81, 1'b1, 1'b0, 8'h00));

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 16;
        rx_idle_pct = 49;
        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].is_cfg)
                load_seeds(dir_tbl[k].p_val, dir_tbl[k].g_val);
            else
                send_item(dir_tbl[k].op, dir_tbl[k].data, dir_tbl[k].last,
                          dir_tbl[k].typed, dir_tbl[k].want);
        end

        // alternating encrypt and decrypt bytes over freshly generated tables
        load_seeds($urandom, $urandom);
        send_item(OP_GENERATE, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
        for (k = 0; k < SWEEP_ITEMS; k++)
            send_item(k[0] ? OP_DECRYPT : OP_ENCRYPT, 8'($urandom), 1'($urandom),
                      1'b0, 8'h00);

        // sender seldom idle, receiver slow; one long receiver hold to back the block up
        load_seeds($urandom, $urandom);
        send_item(OP_GENERATE, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
        hold_req++;
        run_random(300);
        wait_drained();
        run_random(300);

        tx_idle_pct = 49;
        rx_idle_pct = 16;
        load_seeds(32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_GENERATE, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
        run_random(600);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_seeds($urandom, $urandom);
        send_item(OP_GENERATE, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
        run_random(600);

        wait_idle();
        $display("%0d transactions sent (%0d table generations, %0d counter resets), %0d results",
                 items_sent, gens_sent, resets_sent, results_seen);
        $display("covered: unkeyed bypass, seed extremes, reseeding, stalls on both sides");
        if (mismatch_cnt == 0) begin
            $display("[counter_indexed_table_byte_cipher] OK");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("[counter_indexed_table_byte_cipher] ERROR");
        end
        $finish;
    end

endmodule
